// ===== rtl/pixel_control_frame_parser_macros.svh =====
// ----------------------------------------------------------------------------
// pixel control frame parser assertion macros
// shared concurrent check forms, clocked, disabled during reset
// ----------------------------------------------------------------------------
`ifndef PIXEL_CONTROL_FRAME_PARSER_MACROS_SVH
`define PIXEL_CONTROL_FRAME_PARSER_MACROS_SVH

// same-cycle implication
`define PCFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcfp check failed");

// next-cycle implication
`define PCFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcfp check failed");

`endif

// ===== rtl/pcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// pcfp_pkg
// types and constants of the pixel control frame parser
// ----------------------------------------------------------------------------
package pcfp_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned LISTEN_W     = 8;
    localparam int unsigned LED_COUNT_W  = 12;
    localparam int unsigned LENGTH_W     = 16;
    localparam int unsigned INDEX_W      = 11;
    localparam int unsigned COLOR_W      = 8;
    localparam int unsigned CFG_INDEX_W  = 1;
    localparam int unsigned CFG_DATA_W   = 12;
    localparam int unsigned MAX_PIXELS   = 2048;
    localparam int unsigned TRIPLE_BYTES = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_LISTEN_CHANNEL = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LED_COUNT      = 1'b1;

    localparam logic [LISTEN_W-1:0]    LISTEN_RESET    = 8'd1;
    localparam logic [LED_COUNT_W-1:0] LED_COUNT_RESET = 12'd30;
    localparam logic [LED_COUNT_W-1:0] PIXEL_CAP       = LED_COUNT_W'(MAX_PIXELS);
    localparam logic [LISTEN_W-1:0]    BROADCAST_CH    = 8'd0;
    localparam logic [BYTE_W-1:0]      CMD_SET_PIXELS  = 8'd0;

    typedef enum logic [1:0] {
        EV_PIXEL      = 2'd0,
        EV_PIXEL_SHOW = 2'd1,
        EV_SHOW       = 2'd2
    } event_kind_t;

    typedef struct packed {
        event_kind_t          kind;
        logic [INDEX_W-1:0]   pixel_index;
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
    } pcfp_event_t;

    typedef struct packed {
        logic        valid;
        pcfp_event_t data;
    } pcfp_push_t;

    typedef struct packed {
        logic [LISTEN_W-1:0]    listen_channel;
        logic [LED_COUNT_W-1:0] led_count;
    } pcfp_cfg_t;

endpackage

// ===== rtl/pcfp_byte_if.sv =====
// ----------------------------------------------------------------------------
// pcfp_byte_if
// byte stream channel: one frame byte and a drop flag per transaction
// ----------------------------------------------------------------------------
interface pcfp_byte_if;
    import pcfp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              drop;

    modport source (output valid, output data_byte, output drop, input ready);
    modport sink   (input valid, input data_byte, input drop, output ready);
endinterface

// ===== rtl/pcfp_event_if.sv =====
// ----------------------------------------------------------------------------
// pcfp_event_if
// event channel: one pixel write or show per transaction
// ----------------------------------------------------------------------------
interface pcfp_event_if;
    import pcfp_pkg::*;

    logic               valid;
    logic               ready;
    event_kind_t        event_kind;
    logic [INDEX_W-1:0] pixel_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;

    modport source (output valid, output event_kind, output pixel_index,
                    output red, output green, output blue, input ready);
    modport sink   (input valid, input event_kind, input pixel_index,
                    input red, input green, input blue, output ready);
endinterface

// ===== rtl/pcfp_front.sv =====
// ----------------------------------------------------------------------------
// pcfp_front
// byte parser: header decode, frame filter, rgb assembly, event generation
// ----------------------------------------------------------------------------
`include "pixel_control_frame_parser_macros.svh"

module pcfp_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    pcfp_byte_if.sink            byte_stream,
    input  pcfp_pkg::pcfp_cfg_t  cfg,
    input  logic                 q_full,
    output pcfp_pkg::pcfp_push_t q_push
);
    import pcfp_pkg::*;

    typedef enum logic [4:0] {
        ST_CHANNEL  = 5'b00001,
        ST_COMMAND  = 5'b00010,
        ST_LEN_HIGH = 5'b00100,
        ST_LEN_LOW  = 5'b01000,
        ST_PAYLOAD  = 5'b10000
    } state_t;

    localparam logic [1:0] TRIPLE_RED   = 2'd0;
    localparam logic [1:0] TRIPLE_GREEN = 2'd1;
    localparam logic [1:0] TRIPLE_BLUE  = 2'd2;

    state_t                 state_reg,      state_next;
    logic                   writing_reg,    writing_next;
    logic [1:0]             triple_reg,     triple_next;
    logic [LED_COUNT_W-1:0] pix_count_reg,  pix_count_next;
    logic [LENGTH_W-1:0]    bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0]      channel_reg,    channel_next;
    logic [BYTE_W-1:0]      command_reg,    command_next;
    logic [BYTE_W-1:0]      len_high_reg,   len_high_next;
    logic [COLOR_W-1:0]     red_reg,        red_next;
    logic [COLOR_W-1:0]     green_reg,      green_next;

    logic                   accept;
    logic [LENGTH_W-1:0]    length;
    logic [LENGTH_W-1:0]    bytes_after;
    logic [LED_COUNT_W-1:0] cap;
    logic [LED_COUNT_W-1:0] pix_count_inc;
    logic                   frame_ok;
    logic                   frame_empty;
    logic                   last_pixel;

    assign byte_stream.ready = !q_full;
    assign accept            = byte_stream.valid && byte_stream.ready;

    always_comb
    begin
        cap           = (cfg.led_count > PIXEL_CAP) ? PIXEL_CAP : cfg.led_count;
        length        = {len_high_reg, byte_stream.data_byte};
        frame_ok      = ((channel_reg == BROADCAST_CH) || (channel_reg == cfg.listen_channel))
                        && (command_reg == CMD_SET_PIXELS);
        frame_empty   = (length < LENGTH_W'(TRIPLE_BYTES)) || (cap == '0);
        bytes_after   = bytes_left_reg - LENGTH_W'(1);
        pix_count_inc = pix_count_reg + LED_COUNT_W'(1);
        last_pixel    = (pix_count_inc == cap) || (bytes_after < LENGTH_W'(TRIPLE_BYTES));
    end

    always_comb
    begin
        state_next      = state_reg;
        writing_next    = writing_reg;
        triple_next     = triple_reg;
        pix_count_next  = pix_count_reg;
        bytes_left_next = bytes_left_reg;
        channel_next    = channel_reg;
        command_next    = command_reg;
        len_high_next   = len_high_reg;
        red_next        = red_reg;
        green_next      = green_reg;

        q_push.valid            = 1'b0;
        q_push.data.kind        = EV_SHOW;
        q_push.data.pixel_index = '0;
        q_push.data.red         = '0;
        q_push.data.green       = '0;
        q_push.data.blue        = '0;

        if (accept)
        begin
            if (byte_stream.drop)
            begin
                state_next = ST_CHANNEL;
            end
            else
            begin
                case (state_reg)
                    ST_CHANNEL:
                    begin
                        channel_next = byte_stream.data_byte;
                        state_next   = ST_COMMAND;
                    end
                    ST_COMMAND:
                    begin
                        command_next = byte_stream.data_byte;
                        state_next   = ST_LEN_HIGH;
                    end
                    ST_LEN_HIGH:
                    begin
                        len_high_next = byte_stream.data_byte;
                        state_next    = ST_LEN_LOW;
                    end
                    ST_LEN_LOW:
                    begin
                        bytes_left_next = length;
                        pix_count_next  = '0;
                        triple_next     = TRIPLE_RED;
                        writing_next    = frame_ok && !frame_empty;
                        q_push.valid    = frame_ok && frame_empty;
                        state_next      = (length != '0) ? ST_PAYLOAD : ST_CHANNEL;
                    end
                    ST_PAYLOAD:
                    begin
                        bytes_left_next = bytes_after;
                        if (writing_reg)
                        begin
                            case (triple_reg)
                                TRIPLE_RED:
                                begin
                                    red_next    = byte_stream.data_byte;
                                    triple_next = TRIPLE_GREEN;
                                end
                                TRIPLE_GREEN:
                                begin
                                    green_next  = byte_stream.data_byte;
                                    triple_next = TRIPLE_BLUE;
                                end
                                default:
                                begin
                                    q_push.valid            = 1'b1;
                                    q_push.data.kind        = last_pixel ? EV_PIXEL_SHOW
                                                                         : EV_PIXEL;
                                    q_push.data.pixel_index = pix_count_reg[INDEX_W-1:0];
                                    q_push.data.red         = red_reg;
                                    q_push.data.green       = green_reg;
                                    q_push.data.blue        = byte_stream.data_byte;
                                    pix_count_next          = pix_count_inc;
                                    triple_next             = TRIPLE_RED;
                                    if (last_pixel)
                                    begin
                                        writing_next = 1'b0;
                                    end
                                end
                            endcase
                        end
                        if (bytes_after == '0)
                        begin
                            state_next = ST_CHANNEL;
                        end
                    end
                    default:
                    begin
                        state_next = ST_CHANNEL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CHANNEL;
            writing_reg    <= 1'b0;
            triple_reg     <= TRIPLE_RED;
            pix_count_reg  <= '0;
            bytes_left_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            writing_reg    <= writing_next;
            triple_reg     <= triple_next;
            pix_count_reg  <= pix_count_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        channel_reg  <= channel_next;
        command_reg  <= command_next;
        len_high_reg <= len_high_next;
        red_reg      <= red_next;
        green_reg    <= green_next;
    end

    // events only come from accepted, kept bytes
    `PCFP_ASSERT_IMP(a_push_on_accept, clk, rst_n, q_push.valid, accept && !byte_stream.drop)
    // show only is issued at the last header byte
    `PCFP_ASSERT_IMP(a_show_at_header, clk, rst_n, q_push.valid && (q_push.data.kind == EV_SHOW),
                     state_reg == ST_LEN_LOW)
    // pixel events only while an accepted frame still writes
    `PCFP_ASSERT_IMP(a_pixel_in_payload, clk, rst_n,
                     q_push.valid && (q_push.data.kind != EV_SHOW),
                     (state_reg == ST_PAYLOAD) && writing_reg)

endmodule

// ===== rtl/pcfp_queue.sv =====
// ----------------------------------------------------------------------------
// pcfp_queue
// short event queue between parser and output stage
// ----------------------------------------------------------------------------
`include "pixel_control_frame_parser_macros.svh"

module pcfp_queue
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pcfp_pkg::pcfp_push_t  push,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output pcfp_pkg::pcfp_event_t head
);
    import pcfp_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    pcfp_event_t       entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entries_reg[wr_ptr_reg] <= push.data;
        end
    end

    `PCFP_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `PCFP_ASSERT_IMP(a_no_overflow, clk, rst_n, push.valid, !full)
    `PCFP_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, !empty)
    `PCFP_ASSERT_NXT(a_count_up, clk, rst_n, push.valid && !pop,
                     count_reg == $past(count_reg) + CNT_W'(1))

endmodule

// ===== rtl/pcfp_back.sv =====
// ----------------------------------------------------------------------------
// pcfp_back
// output register stage: drains the event queue onto the event channel
// ----------------------------------------------------------------------------
module pcfp_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  empty,
    input  pcfp_pkg::pcfp_event_t head,
    output logic                  pop,
    pcfp_event_if.source          event_stream
);
    import pcfp_pkg::*;

    logic        valid_reg, valid_next;
    pcfp_event_t event_reg;

    assign pop        = !empty && (!valid_reg || event_stream.ready);
    assign valid_next = pop || (valid_reg && !event_stream.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            event_reg <= head;
        end
    end

    assign event_stream.valid       = valid_reg;
    assign event_stream.event_kind  = event_reg.kind;
    assign event_stream.pixel_index = event_reg.pixel_index;
    assign event_stream.red         = event_reg.red;
    assign event_stream.green       = event_reg.green;
    assign event_stream.blue        = event_reg.blue;

endmodule

// ===== rtl/pixel_control_frame_parser.sv =====
// ----------------------------------------------------------------------------
// pixel_control_frame_parser
// pixel control frame parser: byte stream in, pixel write and show events out
//
// channel       dir   payload                                     width
// byte_stream   in    data_byte, drop                             8 + 1
// event_stream  out   event_kind, pixel_index, red, green, blue   2 + 11 + 8 + 8 + 8
// cfg           in    cfg_we, cfg_index, cfg_wdata                1 + 1 + 12
//
// one byte per cycle while byte_stream.ready is high; each byte gives at most one event
// an event passes through the queue and the output register before it is valid on event_stream
// byte_stream.ready drops only while the queue holds QUEUE_DEPTH events
// reset returns the parser to the header and config to its reset values
// ----------------------------------------------------------------------------
module pixel_control_frame_parser
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    pcfp_byte_if.sink                           byte_stream,
    pcfp_event_if.source                        event_stream,
    input  logic                                cfg_we,
    input  logic [pcfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pcfp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import pcfp_pkg::*;

    logic [LISTEN_W-1:0]    listen_channel_reg;
    logic [LED_COUNT_W-1:0] led_count_reg;
    pcfp_cfg_t              cfg;
    pcfp_push_t             q_push;
    pcfp_event_t            q_head;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listen_channel_reg <= LISTEN_RESET;
            led_count_reg      <= LED_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LISTEN_CHANNEL: listen_channel_reg <= cfg_wdata[LISTEN_W-1:0];
                CFG_LED_COUNT:      led_count_reg      <= cfg_wdata[LED_COUNT_W-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg.listen_channel = listen_channel_reg;
    assign cfg.led_count      = led_count_reg;

    pcfp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .cfg         (cfg),
        .q_full      (q_full),
        .q_push      (q_push)
    );

    pcfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .head  (q_head)
    );

    pcfp_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (q_empty),
        .head         (q_head),
        .pop          (q_pop),
        .event_stream (event_stream)
    );

endmodule

// ===== sim/pixel_control_frame_parser_test.sv =====
// ----------------------------------------------------------------------------
// pixel_control_frame_parser_test
// drives pixel-control byte streams through the parser with random idle and
// stall cycles on both channels; a directed table covers the header, accept
// and reject paths, drop and leftover bytes, then random frames run under
// several listen channel and led count settings, ending with a led count
// above the pixel cap; every event is checked against its table row or a predictor
// ----------------------------------------------------------------------------
module pixel_control_frame_parser_test;
    import pcfp_pkg::*;

    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned N_DIRECTED    = 30;
    localparam int unsigned REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              drop;
        logic              typed;
        logic              yields;
        pcfp_event_t       ev;
    } stim_row_t;

    localparam pcfp_event_t NO_EVENT = '0;

    // typed rows carry their event; the rest rely on the predictor
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // listen channel, length 7: two pixels, then one leftover byte
        '{8'h01, 1'b0, 1'b1, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h07, 1'b0, 1'b1, 1'b0, NO_EVENT},
        '{8'hff, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h80, 1'b0, 1'b1, 1'b1, '{EV_PIXEL, 11'd0, 8'hff, 8'h00, 8'h80}},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'hff, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h01, 1'b0, 1'b1, 1'b1, '{EV_PIXEL_SHOW, 11'd1, 8'h00, 8'hff, 8'h01}},
        '{8'h5a, 1'b0, 1'b1, 1'b0, NO_EVENT},
        // foreign channel, zero length: no show
        '{8'h02, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_EVENT},
        // unknown command, payload skipped
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'hff, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h01, 1'b0, 1'b1, 1'b0, NO_EVENT},
        '{8'h7e, 1'b0, 1'b1, 1'b0, NO_EVENT},
        // drop inside a payload, then a zero-length broadcast frame
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h06, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h12, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'hff, 1'b1, 1'b1, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b1, 1'b1, '{EV_SHOW, 11'd0, 8'h00, 8'h00, 8'h00}}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    pcfp_byte_if  byte_ch ();
    pcfp_event_if event_ch ();

    pixel_control_frame_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_stream  (byte_ch),
        .event_stream (event_ch),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always #6 clk = ~clk;

    // parser mirror
    logic [LISTEN_W-1:0]    cfg_listen = LISTEN_RESET;
    logic [LED_COUNT_W-1:0] cfg_leds   = LED_COUNT_RESET;
    logic                   in_body    = 1'b0;
    logic [1:0]             hdr_pos    = '0;
    logic [BYTE_W-1:0]      hdr_channel = '0;
    logic [BYTE_W-1:0]      hdr_command = '0;
    logic [BYTE_W-1:0]      len_msb    = '0;
    logic [LENGTH_W-1:0]    body_left  = '0;
    logic [LED_COUNT_W-1:0] pix_left   = '0;
    logic [INDEX_W-1:0]     pix_next   = '0;
    logic [1:0]             color_pos  = '0;
    logic [COLOR_W-1:0]     red_hold   = '0;
    logic [COLOR_W-1:0]     green_hold = '0;

    pcfp_event_t pending_events [$];
    int unsigned fail_count  = 0;
    int unsigned sent_items  = 0;
    int unsigned quiet_count = 0;
    bit          steady      = 1'b0;

    function automatic void parse_byte(input logic [BYTE_W-1:0] b, input logic drp,
                                       output logic hit, output pcfp_event_t ev);
        logic [LENGTH_W-1:0] length;
        logic [LENGTH_W-1:0] pix;
        logic [LED_COUNT_W-1:0] cap;
        logic accepted;
        hit = 1'b0;
        ev  = '0;
        if (drp)
        begin
            in_body = 1'b0;
            hdr_pos = '0;
            return;
        end
        if (!in_body)
        begin
            case (hdr_pos)
                2'd0:
                begin
                    hdr_channel = b;
                    hdr_pos = 2'd1;
                end
                2'd1:
                begin
                    hdr_command = b;
                    hdr_pos = 2'd2;
                end
                2'd2:
                begin
                    len_msb = b;
                    hdr_pos = 2'd3;
                end
                default:
                begin
                    length = {len_msb, b};
                    cap = (cfg_leds > PIXEL_CAP) ? PIXEL_CAP : cfg_leds;
                    pix = length / LENGTH_W'(TRIPLE_BYTES);
                    if (pix > LENGTH_W'(cap))
                        pix = LENGTH_W'(cap);
                    accepted = (hdr_channel == BROADCAST_CH || hdr_channel == cfg_listen)
                               && hdr_command == CMD_SET_PIXELS;
                    pix_left  = accepted ? pix[LED_COUNT_W-1:0] : '0;
                    body_left = length;
                    pix_next  = '0;
                    color_pos = '0;
                    hdr_pos   = '0;
                    in_body   = (length != 0);
                    if (accepted && pix_left == 0)
                    begin
                        hit = 1'b1;
                        ev.kind = EV_SHOW;
                    end
                end
            endcase
            return;
        end
        body_left = body_left - 1'b1;
        if (pix_left != 0)
        begin
            case (color_pos)
                2'd0:
                begin
                    red_hold = b;
                    color_pos = 2'd1;
                end
                2'd1:
                begin
                    green_hold = b;
                    color_pos = 2'd2;
                end
                default:
                begin
                    pix_left = pix_left - 1'b1;
                    hit = 1'b1;
                    ev.kind = (pix_left == 0) ? EV_PIXEL_SHOW : EV_PIXEL;
                    ev.pixel_index = pix_next;
                    ev.red   = red_hold;
                    ev.green = green_hold;
                    ev.blue  = b;
                    pix_next = pix_next + 1'b1;
                    color_pos = '0;
                end
            endcase
        end
        if (body_left == 0)
        begin
            in_body = 1'b0;
            hdr_pos = '0;
        end
    endfunction

    function automatic int unsigned draw_gap();
        if (steady)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    function automatic stim_row_t plain(input logic [BYTE_W-1:0] value, input logic drp);
        stim_row_t row;
        row = '0;
        row.data_byte = value;
        row.drop = drp;
        return row;
    endfunction

    function automatic void report_event(input string what, input pcfp_event_t want,
                                         input pcfp_event_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display({"%0t %s: expected kind %0d pixel %0d rgb %h %h %h,",
                      " got kind %0d pixel %0d rgb %h %h %h"},
                     $realtime, what, want.kind, want.pixel_index, want.red, want.green,
                     want.blue, got.kind, got.pixel_index, got.red, got.green, got.blue);
    endfunction

    task automatic send_byte(input stim_row_t row);
        int unsigned gap;
        logic hit;
        pcfp_event_t predicted;
        gap = draw_gap();
        if (gap != 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= row.data_byte;
        byte_ch.drop      <= row.drop;
        do @(posedge clk); while (!byte_ch.ready);
        parse_byte(row.data_byte, row.drop, hit, predicted);
        if (row.typed)
        begin
            if (row.yields)
                pending_events.push_back(row.ev);
        end
        else if (hit)
            pending_events.push_back(predicted);
        sent_items++;
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] channel, input logic [BYTE_W-1:0] command,
                              input logic [LENGTH_W-1:0] length, input int cut_at);
        logic [BYTE_W-1:0] head [4];
        int total;
        head = '{channel, command, length[15:8], length[7:0]};
        total = 4 + int'(length);
        for (int i = 0; i < total; i++)
        begin
            if (i == cut_at)
            begin
                send_byte(plain(8'($urandom), 1'b1));
                return;
            end
            send_byte(plain((i < 4) ? head[i] : 8'($urandom), 1'b0));
        end
    endtask

    task automatic random_traffic(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned pixels;
        logic [BYTE_W-1:0] channel;
        logic [BYTE_W-1:0] command;
        logic [LENGTH_W-1:0] length;
        int cut_at;
        stop_at = sent_items + n_items;
        while (sent_items < stop_at)
        begin
            steady = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                // garbage, always closed by a drop to resync
                repeat ($urandom_range(0, 5)) send_byte(plain(8'($urandom), 1'b0));
                send_byte(plain(8'($urandom), 1'b1));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       channel = BROADCAST_CH;
                    1, 2:    channel = cfg_listen;
                    default: channel = 8'($urandom);
                endcase
                command = ($urandom_range(0, 7) == 0) ? 8'($urandom) : CMD_SET_PIXELS;
                pixels = (cfg_leds < 12) ? cfg_leds : 12;
                case ($urandom_range(0, 9))
                    0, 1:    length = 16'($urandom_range(0, 5));
                    2, 3, 4: length = 16'(3 * $urandom_range(0, pixels));
                    5, 6, 7: length = 16'(3 * pixels + $urandom_range(0, 4));
                    8:       length = 16'($urandom_range(0, 40));
                    default: length = 16'($urandom_range(250, 300));
                endcase
                cut_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 3 + length)) : -1;
                send_frame(channel, command, length, cut_at);
            end
        end
        steady = 1'b0;
    endtask

    task automatic settle();
        byte_ch.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [LISTEN_W-1:0] listen, input logic [LED_COUNT_W-1:0] leds);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LISTEN_CHANNEL;
        cfg_wdata <= CFG_DATA_W'(listen);
        @(posedge clk);
        cfg_index <= CFG_LED_COUNT;
        cfg_wdata <= CFG_DATA_W'(leds);
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_listen = listen;
        cfg_leds   = leds;
    endtask

    // event sink with random stalls
    initial
    begin
        int unsigned gap;
        event_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap != 0)
            begin
                event_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            event_ch.ready <= 1'b1;
            do @(posedge clk); while (!event_ch.valid);
        end
    end

    always @(posedge clk)
    begin : check_events
        pcfp_event_t seen;
        pcfp_event_t want;
        if (rst_n && event_ch.valid && event_ch.ready)
        begin
            seen.kind        = event_ch.event_kind;
            seen.pixel_index = event_ch.pixel_index;
            seen.red         = event_ch.red;
            seen.green       = event_ch.green;
            seen.blue        = event_ch.blue;
            if (pending_events.size() == 0)
                report_event("event with none pending", NO_EVENT, seen);
            else
            begin
                want = pending_events.pop_front();
                if (seen.kind !== want.kind || seen.pixel_index !== want.pixel_index
                    || seen.red !== want.red || seen.green !== want.green
                    || seen.blue !== want.blue)
                    report_event("event mismatch", want, seen);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((byte_ch.valid && byte_ch.ready) || (event_ch.valid && event_ch.ready))
                quiet_count = 0;
            else
                quiet_count++;
            if (quiet_count >= QUIET_LIMIT)
            begin
                $display("pixel_control_frame_parser regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        byte_ch.drop      <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_LISTEN_CHANNEL;
        cfg_wdata         <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(DIRECTED_ROWS[i]);

        settle();
        set_config(8'd0, 12'd0);
        random_traffic(150);
        settle();
        set_config(8'd255, 12'd1);
        random_traffic(150);
        settle();
        set_config(8'($urandom), 12'd2048);
        random_traffic(150);
        settle();
        set_config(8'($urandom), 12'($urandom_range(2, 12)));
        random_traffic(150);
        settle();
        set_config(LISTEN_RESET, 12'($urandom_range(13, 40)));
        random_traffic(150);

        // led count above the cap
        settle();
        set_config(8'($urandom), 12'hfff);
        send_frame(BROADCAST_CH, CMD_SET_PIXELS, 16'd101, -1);
        random_traffic(30);
        settle();

        if (fail_count == 0)
            $display("pixel_control_frame_parser regression: pass");
        else
            $display("pixel_control_frame_parser regression: fail");
        $finish;
    end

endmodule
